// ===== rtl/hrx_pkg.sv =====
// Package with the shared types and constants of the frame receiver.
package hrx_pkg;

  localparam logic [7:0] START_BYTE = 8'h10;
  localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_LEN_HI  = 5'b00010,
    PH_LEN_LO  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CHECK   = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_GOOD     = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_DROPPED  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_end;
    status_t    frame_status;
  } result_t;

endpackage

// ===== rtl/hrx_ifs.sv =====
// Handshake interfaces for the receive byte, result and configuration channels.
interface hrx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface hrx_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       frame_end;
  logic [1:0] frame_status;
  modport source (output valid, output payload_byte, output frame_end, output frame_status,
                  input ready);
  modport sink (input valid, input payload_byte, input frame_end, input frame_status,
                output ready);
endinterface

interface hrx_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_payload_length;
  modport source (output valid, output max_payload_length, input ready);
  modport sink (input valid, input max_payload_length, output ready);
endinterface

// ===== rtl/hrx_in_stage.sv =====
// Input register that holds one received word until the parser takes it.
module hrx_in_stage (
  input  logic       clk,
  input  logic       rst,
  hrx_byte_if.sink   rx,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid;
  logic [7:0] data;

  assign rx.ready   = !rst && (!valid || advance);
  assign byte_valid = valid;
  assign byte_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (rx.ready) begin
      valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      data <= rx.rx_byte;
    end
  end

endmodule

// ===== rtl/hrx_parse.sv =====
// Frame parser state and the combinational logic that turns one word into a result.
module hrx_parse (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic [7:0]      byte_data,
  input  logic [15:0]     max_len,
  output logic            res_valid,
  output hrx_pkg::result_t res
);

  hrx_pkg::phase_t phase;
  hrx_pkg::phase_t phase_next;
  logic [15:0]     frame_length;
  logic [15:0]     frame_length_next;
  logic [15:0]     bytes_seen;
  logic [15:0]     bytes_seen_next;
  logic [7:0]      running_sum;
  logic [7:0]      running_sum_next;
  logic [15:0]     full_length;

  assign full_length = {frame_length[15:8], byte_data};

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    bytes_seen_next   = bytes_seen;
    running_sum_next  = running_sum;
    res_valid         = 1'b0;
    res.payload_byte  = byte_data;
    res.frame_end     = 1'b0;
    res.frame_status  = hrx_pkg::ST_DATA;
    case (phase)
      hrx_pkg::PH_LEN_HI: begin
        frame_length_next = {byte_data, 8'h00};
        phase_next        = hrx_pkg::PH_LEN_LO;
      end
      hrx_pkg::PH_LEN_LO: begin
        frame_length_next = full_length;
        bytes_seen_next   = '0;
        running_sum_next  = '0;
        if (full_length > max_len) begin
          phase_next       = hrx_pkg::PH_HUNT;
          res_valid        = 1'b1;
          res.payload_byte = '0;
          res.frame_end    = 1'b1;
          res.frame_status = hrx_pkg::ST_DROPPED;
        end else if (full_length == '0) begin
          phase_next = hrx_pkg::PH_CHECK;
        end else begin
          phase_next = hrx_pkg::PH_PAYLOAD;
        end
      end
      hrx_pkg::PH_PAYLOAD: begin
        running_sum_next = running_sum + byte_data;
        bytes_seen_next  = bytes_seen + 16'd1;
        if (bytes_seen_next >= frame_length) begin
          phase_next = hrx_pkg::PH_CHECK;
        end
        res_valid = 1'b1;
      end
      hrx_pkg::PH_CHECK: begin
        phase_next       = hrx_pkg::PH_HUNT;
        res_valid        = 1'b1;
        res.payload_byte = running_sum;
        res.frame_end    = 1'b1;
        res.frame_status = (byte_data == running_sum) ? hrx_pkg::ST_GOOD
                                                      : hrx_pkg::ST_MISMATCH;
      end
      default: begin
        phase_next = (byte_data == hrx_pkg::START_BYTE) ? hrx_pkg::PH_LEN_HI
                                                        : hrx_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= hrx_pkg::PH_HUNT;
      frame_length <= '0;
      bytes_seen   <= '0;
      running_sum  <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      bytes_seen   <= bytes_seen_next;
      running_sum  <= running_sum_next;
    end
  end

  // A drop status can only come from the low length byte.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.frame_status == hrx_pkg::ST_DROPPED |-> phase == hrx_pkg::PH_LEN_LO)
    else $error("drop status outside the length phase");

  // The closing flag and a non-data status always travel together.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.frame_end == (res.frame_status != hrx_pkg::ST_DATA)))
    else $error("frame end and status disagree");

  // The payload count never passes the frame length.
  assert property (@(posedge clk) disable iff (rst)
    phase == hrx_pkg::PH_PAYLOAD |-> bytes_seen < frame_length)
    else $error("payload count ran past the frame length");

  // A consumed checksum word always sends the parser back to hunting.
  assert property (@(posedge clk) disable iff (rst)
    advance && phase == hrx_pkg::PH_CHECK |=> phase == hrx_pkg::PH_HUNT)
    else $error("parser did not return to hunting after the checksum");

endmodule

// ===== rtl/hrx_out_stage.sv =====
// Result register that holds one result word until the downstream side takes it.
module hrx_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  hrx_pkg::result_t res,
  output logic             slot_free,
  hrx_result_if.source     frame
);

  logic             valid;
  hrx_pkg::result_t data;

  assign slot_free          = !valid || frame.ready;
  assign frame.valid        = valid;
  assign frame.payload_byte = data.payload_byte;
  assign frame.frame_end    = data.frame_end;
  assign frame.frame_status = data.frame_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (slot_free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

endmodule

// ===== rtl/header_length_sum_frame_receiver.sv =====
// Top level of the byte-serial frame receiver with its length limit register.
// The receiver takes one word per cycle while the result register can take a
// result, and gives at most one result word for each word. A word passes
// through the input register, where the parser updates its phase, length,
// count and sum, and then through the result register.
// Bytes outside a frame are dropped silently, each payload byte is passed on as
// it arrives, and the checksum byte or an over-long length closes the frame
// with a status word. The length limit may be written at any time the receiver
// is idle and resets to 4096.
module header_length_sum_frame_receiver (
  input  logic          clk,
  input  logic          rst,
  hrx_byte_if.sink      rx,
  hrx_result_if.source  frame,
  hrx_cfg_if.sink       cfg
);

  logic             byte_valid;
  logic [7:0]       byte_data;
  logic             slot_free;
  logic             advance;
  logic             res_valid;
  hrx_pkg::result_t res;
  logic [15:0]      max_len;

  assign advance   = byte_valid && slot_free;
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= hrx_pkg::MAX_LEN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      max_len <= cfg.max_payload_length;
    end
  end

  hrx_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  hrx_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .byte_data (byte_data),
    .max_len   (max_len),
    .res_valid (res_valid),
    .res       (res)
  );

  hrx_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .res       (res),
    .slot_free (slot_free),
    .frame     (frame)
  );

endmodule

// ===== verif/header_length_sum_frame_receiver_tb.sv =====
// Self-checking testbench for the byte-serial frame receiver with its length limit.
module header_length_sum_frame_receiver_tb;

  localparam int CYCLE_LIMIT = 100000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_CADENCE} ready_mode_t;

  logic clk;
  logic rst;

  hrx_byte_if rx_if ();
  hrx_result_if res_if ();
  hrx_cfg_if cfg_if ();

  header_length_sum_frame_receiver DUT (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_if),
    .frame (res_if),
    .cfg   (cfg_if)
  );

  logic [7:0] pending_rx_bytes[$];
  hrx_pkg::result_t expected_frame_words[$];

  hrx_pkg::phase_t rx_phase = hrx_pkg::PH_HUNT;
  logic [15:0] frame_len = '0;
  logic [15:0] bytes_in_frame = '0;
  logic [7:0] payload_sum = '0;
  logic [15:0] len_limit = hrx_pkg::MAX_LEN_RESET;

  int cycle_count = 0;
  int fail_count = 0;
  int rx_words_taken = 0;
  logic rx_taken = 1'b0;
  logic hold_off;
  int burst_left = 1;
  int gap_left = 0;
  ready_mode_t ready_mode = RDY_ALWAYS;
  int ready_mode_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Advances the parser by one received byte and records the word it should produce, if any.
  task parse_rx_byte(input logic [7:0] b);
    hrx_pkg::result_t w;
    w = '0;
    case (rx_phase)
      hrx_pkg::PH_LEN_HI: begin
        frame_len = {b, 8'h00};
        rx_phase = hrx_pkg::PH_LEN_LO;
      end
      hrx_pkg::PH_LEN_LO: begin
        frame_len = {frame_len[15:8], b};
        bytes_in_frame = '0;
        payload_sum = '0;
        if (frame_len > len_limit) begin
          rx_phase = hrx_pkg::PH_HUNT;
          w.frame_end = 1'b1;
          w.frame_status = hrx_pkg::ST_DROPPED;
          expected_frame_words.push_back(w);
        end else if (frame_len == 16'd0) begin
          rx_phase = hrx_pkg::PH_CHECK;
        end else begin
          rx_phase = hrx_pkg::PH_PAYLOAD;
        end
      end
      hrx_pkg::PH_PAYLOAD: begin
        payload_sum = payload_sum + b;
        bytes_in_frame = bytes_in_frame + 16'd1;
        if (bytes_in_frame >= frame_len) begin
          rx_phase = hrx_pkg::PH_CHECK;
        end
        w.payload_byte = b;
        w.frame_status = hrx_pkg::ST_DATA;
        expected_frame_words.push_back(w);
      end
      hrx_pkg::PH_CHECK: begin
        rx_phase = hrx_pkg::PH_HUNT;
        w.payload_byte = payload_sum;
        w.frame_end = 1'b1;
        if (b == payload_sum) begin
          w.frame_status = hrx_pkg::ST_GOOD;
        end else begin
          w.frame_status = hrx_pkg::ST_MISMATCH;
        end
        expected_frame_words.push_back(w);
      end
      default: begin
        if (b == hrx_pkg::START_BYTE) begin
          rx_phase = hrx_pkg::PH_LEN_HI;
        end else begin
          rx_phase = hrx_pkg::PH_HUNT;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : result_monitor
    hrx_pkg::result_t want;
    if (rst) begin
      rx_taken <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_frame_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result word: byte %02h end %0d status %0d",
                     res_if.payload_byte, res_if.frame_end, res_if.frame_status);
          end
        end else begin
          want = expected_frame_words.pop_front();
          if (res_if.payload_byte !== want.payload_byte ||
              res_if.frame_end !== want.frame_end ||
              res_if.frame_status !== want.frame_status) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result word mismatch: expected %02h/%0d/%0d, got %02h/%0d/%0d",
                       want.payload_byte, want.frame_end, want.frame_status,
                       res_if.payload_byte, res_if.frame_end, res_if.frame_status);
            end
          end
        end
      end
      rx_taken <= rx_if.valid && rx_if.ready;
      if (rx_if.valid && rx_if.ready) begin
        rx_words_taken <= rx_words_taken + 1;
        parse_rx_byte(rx_if.rx_byte);
      end
    end
  end

  always @(negedge clk) begin : rx_driver
    logic next_valid;
    logic [7:0] next_byte;
    next_valid = 1'b0;
    next_byte = rx_if.rx_byte;
    if (rst) begin
      next_valid = 1'b0;
    end else if (rx_if.valid && !rx_taken) begin
      next_valid = 1'b1;
    end else if (gap_left != 0) begin
      gap_left--;
    end else if (pending_rx_bytes.size() != 0) begin
      next_byte = pending_rx_bytes.pop_front();
      next_valid = 1'b1;
      if (burst_left <= 1) begin
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 12);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end
    rx_if.valid <= next_valid;
    rx_if.rx_byte <= next_byte;
  end

  always @(negedge clk) begin : result_ready_driver
    logic rdy;
    if (ready_mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_mode_left = $urandom_range(40, 100);
    end else begin
      ready_mode_left--;
    end
    case (ready_mode)
      RDY_ALWAYS: rdy = 1'b1;
      RDY_COIN: rdy = 1'($urandom_range(0, 1));
      RDY_MOSTLY: rdy = ($urandom_range(0, 7) != 0);
      default: rdy = ((cycle_count % 5) < 2);
    endcase
    res_if.ready <= rdy && !hold_off;
  end

  // A long stall on the result side while bytes keep coming backs the block up.
  initial begin : result_hold_off
    hold_off = 1'b0;
    while (rx_words_taken < 80) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("header_length_sum_frame_receiver test failed");
    $finish;
  end

  task queue_frame(input logic [15:0] len, input bit sum_ok);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'h00;
    pending_rx_bytes.push_back(hrx_pkg::START_BYTE);
    pending_rx_bytes.push_back(len[15:8]);
    pending_rx_bytes.push_back(len[7:0]);
    for (int i = 0; i < int'(len); i++) begin
      b = ($urandom_range(0, 15) == 0) ? hrx_pkg::START_BYTE : 8'($urandom_range(0, 255));
      sum = sum + b;
      pending_rx_bytes.push_back(b);
    end
    if (sum_ok) begin
      pending_rx_bytes.push_back(sum);
    end else begin
      pending_rx_bytes.push_back(sum + 8'($urandom_range(1, 255)));
    end
  endtask

  function automatic logic [15:0] pick_len();
    int top;
    int r;
    r = $urandom_range(0, 19);
    top = (len_limit < 24) ? int'(len_limit) : 24;
    if (r == 0 && len_limit <= 200) begin
      return len_limit;
    end
    if (r == 1) begin
      top = (len_limit < 200) ? int'(len_limit) : 200;
    end
    return 16'($urandom_range(0, top));
  endfunction

  // Mostly well-formed frames, with noise, oversized headers and cut-off headers mixed in.
  task queue_traffic(input int n_bytes);
    int target;
    int r;
    logic [15:0] len;
    target = pending_rx_bytes.size() + n_bytes;
    while (pending_rx_bytes.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 3)) pending_rx_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 16 && len_limit != 16'hFFFF) begin
        if ($urandom_range(0, 1) == 0) begin
          len = len_limit + 16'd1;
        end else begin
          len = 16'($urandom_range(int'(len_limit) + 1, 65535));
        end
        pending_rx_bytes.push_back(hrx_pkg::START_BYTE);
        pending_rx_bytes.push_back(len[15:8]);
        pending_rx_bytes.push_back(len[7:0]);
      end else if (r < 20) begin
        pending_rx_bytes.push_back(hrx_pkg::START_BYTE);
        pending_rx_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 35) begin
        queue_frame(pick_len(), 1'b0);
      end else begin
        queue_frame(pick_len(), 1'b1);
      end
    end
  endtask

  task wait_idle();
    while (pending_rx_bytes.size() != 0 || rx_if.valid || expected_frame_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_len_limit(input logic [15:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.max_payload_length <= value;
    do @(posedge clk); while (!cfg_if.ready);
    len_limit = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin : stimulus
    rst = 1'b1;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = 8'h00;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.max_payload_length = 16'h0000;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    pending_rx_bytes = '{
      8'h00, 8'hFF,
      hrx_pkg::START_BYTE, 8'h00, 8'h00, 8'h00,
      hrx_pkg::START_BYTE, 8'h00, 8'h00, 8'h5A,
      hrx_pkg::START_BYTE, 8'h00, 8'h02, 8'hFF, hrx_pkg::START_BYTE, 8'h0F,
      hrx_pkg::START_BYTE, 8'hFF, 8'hFF,
      hrx_pkg::START_BYTE, 8'h00, 8'h01, 8'h80, 8'h81
    };
    queue_traffic(140);
    wait_idle();

    write_len_limit(16'h0000);
    queue_traffic(60);
    wait_idle();

    write_len_limit(16'hFFFF);
    queue_traffic(110);
    wait_idle();

    write_len_limit(16'($urandom_range(1, 24)));
    queue_traffic(120);
    wait_idle();

    if (fail_count == 0) begin
      $display("header_length_sum_frame_receiver test passed");
    end else begin
      $display("header_length_sum_frame_receiver test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hrx_pkg.sv
rtl/hrx_ifs.sv
rtl/hrx_in_stage.sv
rtl/hrx_parse.sv
rtl/hrx_out_stage.sv
rtl/header_length_sum_frame_receiver.sv
verif/header_length_sum_frame_receiver_tb.sv
